### hw/rtl/ice_pkg.sv
// ----------------------------------------------------------------------------
// ice_pkg
// Constants, types and helper functions shared by the Thin-ICE cipher RTL.
// ----------------------------------------------------------------------------
package ice_pkg;

    localparam int RoundCount = 8;
    localparam int BoxCount   = 4;

    typedef logic [19:0]                 subkey_t;
    typedef logic [2:0][19:0]            rkey_t;
    typedef logic [RoundCount-1:0][2:0][19:0] sched_t;

    typedef enum logic
    {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    // Register map, word index in paddr[2]
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic [31:0] KEY_HIGH_RST = 32'h51F30F11;
    localparam logic [31:0] KEY_LOW_RST  = 32'h04246A00;

    localparam logic [8:0] SB_MOD [BoxCount][4] = '{
        '{9'd333, 9'd313, 9'd505, 9'd369},
        '{9'd379, 9'd375, 9'd319, 9'd391},
        '{9'd361, 9'd445, 9'd451, 9'd397},
        '{9'd397, 9'd425, 9'd395, 9'd505}
    };

    localparam logic [7:0] SB_XOR [BoxCount][4] = '{
        '{8'h83, 8'h85, 8'h9B, 8'hCD},
        '{8'hCC, 8'hA7, 8'hAD, 8'h41},
        '{8'h4B, 8'h2E, 8'hD4, 8'h33},
        '{8'hEA, 8'hCB, 8'h2E, 8'h04}
    };

    // destination bit of each source bit of the P-box
    localparam logic [4:0] PERM_POS [32] = '{
        5'd0,  5'd7,  5'd10, 5'd13, 5'd19, 5'd21, 5'd24, 5'd30,
        5'd3,  5'd5,  5'd8,  5'd14, 5'd16, 5'd23, 5'd26, 5'd29,
        5'd2,  5'd4,  5'd9,  5'd15, 5'd17, 5'd22, 5'd27, 5'd28,
        5'd1,  5'd6,  5'd11, 5'd12, 5'd18, 5'd20, 5'd25, 5'd31
    };

    localparam logic [1:0] ROT_ORDER [RoundCount] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0
    };

    // GF(2^8) multiply with a per-row modulus
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [8:0] m);
        logic [8:0] acc;
        logic [7:0] res;
        res = '0;
        acc = {1'b0, a};
        for (int n = 0; n < 8; n++)
        begin
            if (b[n])
            begin
                res = res ^ acc[7:0];
            end
            acc = {acc[7:0], 1'b0};
            if (acc[8])
            begin
                acc = acc ^ m;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] perm32(input logic [31:0] x);
        logic [31:0] res;
        res = '0;
        for (int n = 0; n < 32; n++)
        begin
            res[PERM_POS[n]] = x[n];
        end
        return res;
    endfunction

    // Key schedule: pure wiring of key bits, some inverted
    function automatic sched_t derive_keys(input logic [31:0] hi, input logic [31:0] lo);
        sched_t           sk;
        logic [3:0][15:0] kw;
        logic [1:0]       t;
        logic             bt;
        kw[3] = hi[31:16];
        kw[2] = hi[15:0];
        kw[1] = lo[31:16];
        kw[0] = lo[15:0];
        sk    = '0;
        for (int r = 0; r < RoundCount; r++)
        begin
            for (int j = 0; j < 15; j++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    t  = ROT_ORDER[r] + 2'(k);
                    bt = kw[t][0];
                    sk[r][j % 3] = {sk[r][j % 3][18:0], bt};
                    kw[t] = {~bt, kw[t][15:1]};
                end
            end
        end
        return sk;
    endfunction

endpackage

### hw/rtl/ice_round.sv
// ----------------------------------------------------------------------------
// ice_round
// One Feistel round in two register stages: key mix and first S-box
// products, then the remaining products, P-box and half swap.
// ----------------------------------------------------------------------------
module ice_round import ice_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_stall,
    input  logic        op,
    input  logic [31:0] half_a,
    input  logic [31:0] half_b,
    input  rkey_t       sk_fwd,
    input  rkey_t       sk_rev,
    output logic        dn_valid,
    input  logic        dn_stall,
    output logic        dn_op,
    output logic [31:0] dn_half_a,
    output logic [31:0] dn_half_b
);

    logic                        a_valid_reg;
    logic                        a_op_reg;
    logic [31:0]                 a_keep_reg;
    logic [31:0]                 a_mix_reg;
    logic [BoxCount-1:0][7:0]    a_base_reg;
    logic [BoxCount-1:0][7:0]    a_cube_reg;
    logic [BoxCount-1:0][1:0]    a_row_reg;

    logic                        b_valid_reg;
    logic                        b_op_reg;
    logic [31:0]                 b_half_a_reg;
    logic [31:0]                 b_half_b_reg;

    logic                        a_en;
    logic                        b_en;
    rkey_t                       sk;
    logic [19:0]                 hl;
    logic [19:0]                 hr;
    logic [19:0]                 sel;
    logic [19:0]                 wl;
    logic [19:0]                 wr;
    logic [BoxCount-1:0][9:0]    idx;
    logic [BoxCount-1:0][7:0]    base_next;
    logic [BoxCount-1:0][7:0]    cube_next;
    logic [BoxCount-1:0][1:0]    row_next;
    logic [31:0]                 f_word;

    assign b_en     = !b_valid_reg || !dn_stall;
    assign a_en     = !a_valid_reg || b_en;
    assign up_stall = !a_en;

    // Stage A: expand, key mix, x^2 and x^3
    always_comb
    begin
        logic [7:0] sq;
        sk  = (op == OP_DECRYPT) ? sk_rev : sk_fwd;
        hl  = {half_b[1:0], half_b[31:24], half_b[25:16]};
        hr  = {half_b[17:8], half_b[9:0]};
        sel = sk[2] & (hl ^ hr);
        wr  = sel ^ hr ^ sk[1];
        wl  = sel ^ hl ^ sk[0];
        idx[0] = wl[19:10];
        idx[1] = wl[9:0];
        idx[2] = wr[19:10];
        idx[3] = wr[9:0];
        for (int i = 0; i < BoxCount; i++)
        begin
            row_next[i]  = {idx[i][9], idx[i][0]};
            base_next[i] = idx[i][8:1] ^ SB_XOR[i][row_next[i]];
            sq           = gf_mul(base_next[i], base_next[i], SB_MOD[i][row_next[i]]);
            cube_next[i] = gf_mul(base_next[i], sq, SB_MOD[i][row_next[i]]);
        end
    end

    // Stage B: x^6, x^7, P-box
    always_comb
    begin
        logic [7:0] x6;
        logic [7:0] x7;
        f_word = '0;
        for (int i = 0; i < BoxCount; i++)
        begin
            x6 = gf_mul(a_cube_reg[i], a_cube_reg[i], SB_MOD[i][a_row_reg[i]]);
            x7 = gf_mul(a_base_reg[i], x6, SB_MOD[i][a_row_reg[i]]);
            f_word = f_word | perm32(32'(x7) << (8 * (BoxCount - 1 - i)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && up_valid)
        begin
            a_op_reg   <= op;
            a_keep_reg <= half_b;
            a_mix_reg  <= half_a;
            a_base_reg <= base_next;
            a_cube_reg <= cube_next;
            a_row_reg  <= row_next;
        end
        // swap halves on the way out
        if (b_en && a_valid_reg)
        begin
            b_op_reg     <= a_op_reg;
            b_half_a_reg <= a_keep_reg;
            b_half_b_reg <= a_mix_reg ^ f_word;
        end
    end

    assign dn_valid  = b_valid_reg;
    assign dn_op     = b_op_reg;
    assign dn_half_a = b_half_a_reg;
    assign dn_half_b = b_half_b_reg;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_en |=> a_valid_reg && $stable(a_mix_reg))
        else $error("stage A dropped a stalled word");

    b_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && dn_stall |=> b_valid_reg && $stable(b_half_b_reg))
        else $error("stage B changed a stalled word");

    stall_from_back: assert property (@(posedge clk) disable iff (!rst_n)
        up_stall |-> a_valid_reg && b_valid_reg && dn_stall)
        else $error("round stalled with room to advance");

endmodule

### hw/rtl/ice_block_cipher.sv
// ----------------------------------------------------------------------------
// ice_block_cipher
// Thin-ICE cipher, eight Feistel rounds on a 64-bit block, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries opcode and block_in; a word is
//   taken at a clock edge with in_valid high and in_stall low. opcode selects
//   encrypt or decrypt (subkeys in reverse order).
//   Output channel (out_valid / out_stall) carries block_out.
//   Each round is two register stages, so the pipe is 16 stages deep. One
//   block enters per cycle while the output is not stalled; throughput is one
//   block per cycle, since every stage advances whenever the stage after it
//   moves or is empty.
//   The key sits in two APB registers (key_high at 0x0, key_low at 0x4);
//   write them only while the pipe is empty.
//   Reset clears all valid bits and loads the default key.
//   When the receiver stalls, stages fill up behind the output register and
//   in_stall rises only once every stage holds a word; nothing is lost.
// ----------------------------------------------------------------------------
module ice_block_cipher import ice_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [63:0] block_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] block_out
);

    logic [31:0]              key_high_reg;
    logic [31:0]              key_low_reg;
    logic                     cfg_write;
    sched_t                   sched;

    logic [RoundCount:0]      v_chain;
    logic [RoundCount:0]      s_chain;
    logic [RoundCount-1:0]    op_chain;
    logic [RoundCount:0][31:0] ha_chain;
    logic [RoundCount:0][31:0] hb_chain;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= KEY_HIGH_RST;
            key_low_reg  <= KEY_LOW_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                default:      key_high_reg <= key_high_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_KEY_LOW) ? key_low_reg : key_high_reg;

    assign sched = derive_keys(key_high_reg, key_low_reg);

    assign v_chain[0]  = in_valid;
    assign in_stall    = s_chain[0];
    assign op_chain[0] = opcode;
    assign ha_chain[0] = block_in[63:32];
    assign hb_chain[0] = block_in[31:0];

    for (genvar i = 0; i < RoundCount; i++)
    begin : g_round
        if (i < RoundCount - 1)
        begin : g_mid
            ice_round u_round
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (v_chain[i]),
                .up_stall  (s_chain[i]),
                .op        (op_chain[i]),
                .half_a    (ha_chain[i]),
                .half_b    (hb_chain[i]),
                .sk_fwd    (sched[i]),
                .sk_rev    (sched[RoundCount-1-i]),
                .dn_valid  (v_chain[i+1]),
                .dn_stall  (s_chain[i+1]),
                .dn_op     (op_chain[i+1]),
                .dn_half_a (ha_chain[i+1]),
                .dn_half_b (hb_chain[i+1])
            );
        end
        else
        begin : g_last
            ice_round u_round
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (v_chain[i]),
                .up_stall  (s_chain[i]),
                .op        (op_chain[i]),
                .half_a    (ha_chain[i]),
                .half_b    (hb_chain[i]),
                .sk_fwd    (sched[i]),
                .sk_rev    (sched[RoundCount-1-i]),
                .dn_valid  (v_chain[i+1]),
                .dn_stall  (s_chain[i+1]),
                .dn_op     (),
                .dn_half_a (ha_chain[i+1]),
                .dn_half_b (hb_chain[i+1])
            );
        end
    end

    assign s_chain[RoundCount] = out_stall;
    assign out_valid           = v_chain[RoundCount];
    // after an even number of swaps the halves are back in place; block_out gives them swapped
    assign block_out           = {hb_chain[RoundCount], ha_chain[RoundCount]};

    in_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output moves");

    key_holds_without_write: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write |=> $stable(key_high_reg) && $stable(key_low_reg))
        else $error("key changed without a register write");

    out_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(block_out))
        else $error("result changed under stall");

endmodule

### verif/ice_block_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ice_block_cipher_tb
// Drives blocks through the Thin-ICE cipher under changing keys and random
// idle and stall patterns, and checks every output word against a local
// model of the cipher.
// ----------------------------------------------------------------------------
module ice_block_cipher_tb;
    import ice_pkg::*;

    typedef struct packed
    {
        op_t         op;
        logic [63:0] blk;
    } blk_req_t;

    localparam int LatencyCycles = 16;
    localparam int CycleLimit    = 400000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [63:0] block_in;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] block_out;

    blk_req_t    pending_q[$];
    logic [63:0] cipher_q[$];
    logic [31:0] key_hi;
    logic [31:0] key_lo;
    logic        in_taken;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          errors;
    int          blocks_done;
    int          cycles;
    int          key_sets;

    ice_block_cipher uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .block_in  (block_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .block_out (block_out)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // GF(2^8) multiply, reduced by m
    function automatic logic [7:0] fmul(logic [8:0] a, logic [7:0] b, logic [8:0] m);
        logic [7:0] acc;
        acc = '0;
        for (int n = 0; n < 8; n++)
        begin
            if (b[n])
            begin
                acc = acc ^ a[7:0];
            end
            a = {a[7:0], 1'b0};
            if (a[8])
            begin
                a = a ^ m;
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] sbox_out(int box, logic [9:0] idx);
        logic [7:0]  col;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [8:0]  m;
        logic [31:0] v;
        logic [31:0] p;
        int          row;
        // P-box destination of each source bit
        int          dst[32] = '{0, 7, 10, 13, 19, 21, 24, 30, 3, 5, 8, 14, 16, 23, 26, 29,
                                 2, 4, 9, 15, 17, 22, 27, 28, 1, 6, 11, 12, 18, 20, 25, 31};
        row = {idx[9], idx[0]};
        col = idx[8:1] ^ SB_XOR[box][row];
        m   = SB_MOD[box][row];
        y   = 8'd0;
        if (col != 8'd0)
        begin
            x = fmul({1'b0, col}, col, m);
            x = fmul({1'b0, col}, x, m);
            x = fmul({1'b0, x}, x, m);
            y = fmul({1'b0, col}, x, m);
        end
        v = 32'(y) << (24 - 8 * box);
        p = '0;
        for (int n = 0; n < 32; n++)
        begin
            p[dst[n]] = v[n];
        end
        return p;
    endfunction

    function automatic logic [31:0] feistel_f(logic [31:0] p, logic [2:0][19:0] sk);
        logic [19:0] hl;
        logic [19:0] hr;
        logic [19:0] sel;
        logic [19:0] wl;
        logic [19:0] wr;
        hl  = {p[1:0], p[31:24], p[25:16]};
        hr  = {p[17:8], p[9:0]};
        sel = sk[2] & (hl ^ hr);
        wr  = sel ^ hr ^ sk[1];
        wl  = sel ^ hl ^ sk[0];
        return sbox_out(0, wl[19:10]) | sbox_out(1, wl[9:0])
             | sbox_out(2, wr[19:10]) | sbox_out(3, wr[9:0]);
    endfunction

    function automatic logic [63:0] ice_cipher(op_t op, logic [63:0] blk,
                                               logic [31:0] hi, logic [31:0] lo);
        logic [7:0][2:0][19:0] sk;
        logic [3:0][15:0]      kw;
        logic [31:0]           l;
        logic [31:0]           r;
        logic [1:0]            t;
        logic                  kb;
        int                    rot[8] = '{0, 1, 2, 3, 2, 1, 3, 0};
        int                    ra;
        int                    rb;
        kw = {hi, lo};
        sk = '0;
        for (int rd = 0; rd < 8; rd++)
        begin
            for (int j = 0; j < 15; j++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    t  = 2'(rot[rd] + k);
                    kb = kw[t][0];
                    sk[rd][j % 3] = {sk[rd][j % 3][18:0], kb};
                    kw[t] = {~kb, kw[t][15:1]};
                end
            end
        end
        l = blk[63:32];
        r = blk[31:0];
        for (int n = 0; n < 8; n += 2)
        begin
            ra = (op == OP_DECRYPT) ? 7 - n : n;
            rb = (op == OP_DECRYPT) ? 6 - n : n + 1;
            l  = l ^ feistel_f(r, sk[ra]);
            r  = r ^ feistel_f(l, sk[rb]);
        end
        return {r, l};
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_KEY_HIGH)
        begin
            key_hi = data;
        end
        else
        begin
            key_lo = data;
        end
    endtask

    task automatic queue_block(op_t op, logic [63:0] blk);
        blk_req_t req;
        req.op  = op;
        req.blk = blk;
        pending_q.push_back(req);
    endtask

    task automatic drain_pipe();
        while (pending_q.size() != 0 || cipher_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LatencyCycles + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Driver: advance to the next word once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    opcode   <= pending_q[0].op;
                    block_in <= pending_q[0].blk;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                out_stall   <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Pop the request and compute its result when the word is taken
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            cipher_q.push_back(ice_cipher(pending_q[0].op, pending_q[0].blk,
                                          key_hi, key_lo));
            void'(pending_q.pop_front());
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_q.size() == 0)
            begin
                $display("%0t: unexpected block_out %h", $time, block_out);
                errors <= errors + 1;
            end
            else
            begin
                if (block_out !== cipher_q[0])
                begin
                    $display("%0t: block_out expected %h actual %h",
                             $time, cipher_q[0], block_out);
                    errors <= errors + 1;
                end
                void'(cipher_q.pop_front());
            end
            blocks_done <= blocks_done + 1;
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d blocks pending", cycles, cipher_q.size());
            $display("FAIL ice_block_cipher");
            $finish;
        end
    end

    initial
    begin
        int mode_idle[4];
        int mode_stall[4];
        logic [63:0] pt;
        logic [63:0] ct;
        mode_idle  = '{0, 70, 0, 38};
        mode_stall = '{0, 0, 70, 38};
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        in_taken       = 1'b0;
        opcode         = 1'b0;
        block_in       = '0;
        out_stall      = 1'b0;
        key_hi         = KEY_HIGH_RST;
        key_lo         = KEY_LOW_RST;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        errors         = 0;
        blocks_done    = 0;
        cycles         = 0;
        key_sets       = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset, zero and all-ones keys, field extremes, both operations
        queue_block(OP_ENCRYPT, 64'h0);
        queue_block(OP_DECRYPT, 64'h0);
        queue_block(OP_ENCRYPT, '1);
        queue_block(OP_DECRYPT, '1);
        queue_block(OP_ENCRYPT, 64'h0123456789ABCDEF);
        queue_block(OP_DECRYPT, 64'h8000000000000001);
        queue_block(OP_ENCRYPT, 64'hAAAAAAAA55555555);
        queue_block(OP_DECRYPT, 64'h55555555AAAAAAAA);
        drain_pipe();
        apb_write(3'h0, 32'h0);
        apb_write(3'h4, 32'h0);
        queue_block(OP_ENCRYPT, 64'h0);
        queue_block(OP_DECRYPT, '1);
        drain_pipe();
        apb_write(3'h0, '1);
        apb_write(3'h4, '1);
        queue_block(OP_ENCRYPT, '1);
        queue_block(OP_DECRYPT, 64'h0);
        queue_block(OP_ENCRYPT, 64'hFEDCBA9876543210);
        drain_pipe();

        // Random: each phase a new key and idle/stall pattern, round trips included
        for (int ph = 0; ph < 12; ph++)
        begin
            apb_write(3'h0, $urandom);
            apb_write(3'h4, $urandom);
            key_sets++;
            send_idle_pct  = mode_idle[ph % 4];
            recv_stall_pct = mode_stall[ph % 4];
            if (ph == 4)
            begin
                hold_cycles = 300;
            end
            for (int n = 0; n < 64; n++)
            begin
                pt = rand64();
                ct = ice_cipher(OP_ENCRYPT, pt, key_hi, key_lo);
                queue_block(OP_ENCRYPT, pt);
                queue_block(OP_DECRYPT, ct);
            end
            repeat (2)
            begin
                queue_block(op_t'($urandom_range(1)), '1 >> $urandom_range(63));
            end
            drain_pipe();
        end
        $display("%0d blocks checked over %0d random keys plus reset, zero and all-ones keys",
                 blocks_done, key_sets);
        $display("encrypt and decrypt round trips under four idle/stall mixes, one long stall");
        if (errors == 0)
        begin
            $display("PASS ice_block_cipher");
        end
        else
        begin
            $display("FAIL ice_block_cipher");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ice_pkg.sv
hw/rtl/ice_round.sv
hw/rtl/ice_block_cipher.sv
verif/ice_block_cipher_tb.sv
